[hw/rtl/mset_pkg.sv]
// mset_pkg: shared types and codes for the multi-slot event timer
// no dependencies; used by the interfaces, the controller, the datapath
// and the top level
package mset_pkg;

  // default sizes of the bank
  localparam int NUM_SLOTS_DEF  = 16;
  localparam int TIME_WIDTH_DEF = 32;

  // command codes of an input word
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_CREATE  = 2'd1;
  localparam logic [1:0] CMD_DESTROY = 2'd2;
  localparam logic [1:0] CMD_NOP     = 2'd3;

  // result kinds of an output word
  localparam logic [1:0] KIND_FIRED   = 2'd0;
  localparam logic [1:0] KIND_CREATED = 2'd1;
  localparam logic [1:0] KIND_REFUSED = 2'd2;

  // input word payload
  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  slot;
    logic        repeat_mode;
    logic [30:0] delay_ticks;
    logic [30:0] gap_ticks;
    logic [15:0] repeat_count;
    logic [30:0] delta_ticks;
  } req_word_t;

  // output word payload
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot_id;
    logic       last;
  } evt_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic create;
    logic destroy;
    logic scan_start;
    logic scan_read;
    logic scan_skip;
    logic scan_exec;
    logic flush;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       out_free;
    logic       slot_active;
    logic       idx_last;
    logic       pend_valid;
    logic       ex_stall;
  } sts_t;

endpackage

[hw/rtl/mset_if.sv]
// mset_if: valid/ready channel interfaces of the multi-slot event timer
// depends on mset_pkg for the payload types

// command channel
interface mset_req_if;
  logic                  valid;
  logic                  ready;
  mset_pkg::req_word_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// event channel
interface mset_evt_if;
  logic                  valid;
  logic                  ready;
  mset_pkg::evt_word_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/multi_slot_event_timer_unit.sv]
// multi_slot_event_timer_unit: top level of the multi-slot event timer
// depends on mset_pkg, mset_if, mset_ctrl and mset_dp
//
//   channel  modport  words                            when taken
//   req_i    sink     tick / create / destroy / nop    valid && ready
//   evt_o    source   fired / created / refused        valid && ready
//
// a create, destroy or nop passes the idle and decode states; a tick adds a
// read state per idle slot, read and exec states per armed slot (read of the
// slot memory, then update and write back) and a closing flush state.
// a fire word is held back until the next fire so the last one can carry the
// last flag; a full output register stalls the scan only when a second fire
// arrives, and holds a create or the closing flush until the word is taken.
// reset clears the slot flags, scan control and output valid; the slot
// memory needs no clearing since a slot is read only after its create.
module multi_slot_event_timer_unit #(
  parameter int NumSlots  = mset_pkg::NUM_SLOTS_DEF,
  parameter int TimeWidth = mset_pkg::TIME_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mset_req_if.sink    req_i,
  mset_evt_if.source  evt_o
);

  mset_pkg::ctl_t ctl;
  mset_pkg::sts_t sts;

  // sequencer
  mset_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // datapath
  mset_dp #(
    .NumSlots  (NumSlots),
    .TimeWidth (TimeWidth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (req_i.data),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_ready_i (evt_o.ready),
    .out_valid_o (evt_o.valid),
    .out_data_o  (evt_o.data)
  );

endmodule

[hw/rtl/mset_ctrl.sv]
// mset_ctrl: sequencer of the multi-slot event timer
// depends on mset_pkg; drives the datapath through ctl_t, watches sts_t
module mset_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mset_pkg::sts_t   sts_i,
  output mset_pkg::ctl_t   ctl_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DECODE  = 3'd1;
  localparam logic [2:0] ST_SCAN_RD = 3'd2;
  localparam logic [2:0] ST_SCAN_EX = 3'd3;
  localparam logic [2:0] ST_FLUSH   = 3'd4;

  logic [2:0] state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.op)
          mset_pkg::CMD_TICK: begin
            ctl_o.scan_start = 1'b1;
            state_d          = ST_SCAN_RD;
          end
          mset_pkg::CMD_CREATE: begin
            if (sts_i.out_free) begin
              ctl_o.create = 1'b1;
              state_d      = ST_IDLE;
            end
          end
          mset_pkg::CMD_DESTROY: begin
            ctl_o.destroy = 1'b1;
            state_d       = ST_IDLE;
          end
          mset_pkg::CMD_NOP: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_SCAN_RD: begin
        // armed slots get a memory read, idle ones are passed over
        if (sts_i.slot_active) begin
          ctl_o.scan_read = 1'b1;
          state_d         = ST_SCAN_EX;
        end else begin
          ctl_o.scan_skip = 1'b1;
          if (sts_i.idx_last) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_SCAN_EX: begin
        if (!sts_i.ex_stall) begin
          ctl_o.scan_exec = 1'b1;
          state_d         = sts_i.idx_last ? ST_FLUSH : ST_SCAN_RD;
        end
      end
      ST_FLUSH: begin
        // held fire word goes out marked last
        if (!sts_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          ctl_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/mset_dp.sv]
// mset_dp: slot flags, slot memory, countdown arithmetic and output register
// depends on mset_pkg; commanded by mset_ctrl
module mset_dp #(
  parameter int NumSlots  = mset_pkg::NUM_SLOTS_DEF,
  parameter int TimeWidth = mset_pkg::TIME_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mset_pkg::req_word_t  in_data_i,
  input  mset_pkg::ctl_t       ctl_i,
  output mset_pkg::sts_t       sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output mset_pkg::evt_word_t  out_data_o
);

  localparam int SlotW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int LoadW = (TimeWidth > 32) ? TimeWidth : 32;
  localparam int EntW  = 3 * TimeWidth + 16;
  localparam int RldLo = 16;
  localparam int GapLo = 16 + TimeWidth;
  localparam int DlyLo = 16 + 2 * TimeWidth;

  // clamp a 31-bit tick count to the positive ceiling
  function automatic logic [TimeWidth-1:0] load_time(input logic [30:0] v);
    logic [LoadW-1:0] ext;
    logic [LoadW-1:0] ceil;
    ext  = {{(LoadW-31){1'b0}}, v};
    ceil = {{(LoadW-TimeWidth+1){1'b0}}, {(TimeWidth-1){1'b1}}};
    if (ext > ceil) begin
      ext = ceil;
    end
    return ext[TimeWidth-1:0];
  endfunction

  // subtract a non-negative amount, saturating at the negative floor
  function automatic logic [TimeWidth-1:0] sat_sub(input logic [TimeWidth-1:0] a,
                                                   input logic [TimeWidth-1:0] d);
    logic [TimeWidth:0] diff;
    diff = {a[TimeWidth-1], a} - {1'b0, d};
    if (diff[TimeWidth] != diff[TimeWidth-1]) begin
      return {1'b1, {(TimeWidth-1){1'b0}}};
    end
    return diff[TimeWidth-1:0];
  endfunction

  // latched input word
  logic [1:0]           op_q;
  logic [3:0]           slot_q;
  logic                 rep_q;
  logic [TimeWidth-1:0] dly_in_q;
  logic [TimeWidth-1:0] gap_in_q;
  logic [15:0]          cnt_in_q;
  logic [TimeWidth-1:0] delta_q;

  // per-slot flags
  logic [NumSlots-1:0]  in_use_q;
  logic [NumSlots-1:0]  ended_q;
  logic [NumSlots-1:0]  rep_mode_q;

  // slot memory: {delay, gap, reload, count}
  logic [EntW-1:0]      slot_mem_q [NumSlots];
  logic [EntW-1:0]      rd_q;

  // scan state
  logic [SlotW-1:0]     idx_q;
  logic                 pend_valid_q;
  logic [SlotW-1:0]     pend_slot_q;

  // output register
  logic                 out_valid_q;
  mset_pkg::evt_word_t  out_data_q;

  logic [8:0]           slot_ext;
  logic [SlotW-1:0]     slot_addr;
  logic                 slot_ok;
  logic                 create_ok;
  logic [8:0]           pend_ext;
  logic                 out_free;

  logic [TimeWidth-1:0] cur_dly, cur_gap, cur_rld;
  logic [15:0]          cur_cnt;
  logic                 cur_rep;
  logic                 dly_spent, gap_spent;
  logic                 fire;
  logic                 rep_fire;
  logic [15:0]          cnt_n;
  logic [TimeWidth-1:0] gap_a, gap_n, dly_n;
  logic                 end_n;

  logic                 mem_we;
  logic [SlotW-1:0]     mem_wa;
  logic [EntW-1:0]      mem_wd;

  // addressed slot decode
  assign slot_ext  = {5'd0, slot_q};
  assign slot_addr = slot_ext[SlotW-1:0];
  assign slot_ok   = slot_ext < 9'(NumSlots);
  assign create_ok = slot_ok && !(in_use_q[slot_addr] && !ended_q[slot_addr]);
  assign pend_ext  = 9'(pend_slot_q);
  assign out_free  = !out_valid_q || out_ready_i;

  // countdown of the visited slot
  always_comb begin
    cur_dly   = rd_q[DlyLo +: TimeWidth];
    cur_gap   = rd_q[GapLo +: TimeWidth];
    cur_rld   = rd_q[RldLo +: TimeWidth];
    cur_cnt   = rd_q[15:0];
    cur_rep   = rep_mode_q[idx_q];
    dly_spent = cur_dly[TimeWidth-1] || (cur_dly == '0);
    gap_spent = cur_gap[TimeWidth-1] || (cur_gap == '0);
    fire      = cur_rep ? ((cur_cnt != 16'd0) && dly_spent && gap_spent) : dly_spent;
    rep_fire  = cur_rep && fire;
    cnt_n     = rep_fire ? (cur_cnt - 16'd1) : cur_cnt;
    gap_a     = rep_fire ? cur_rld : cur_gap;
    gap_n     = (cur_rep && dly_spent) ? sat_sub(gap_a, delta_q) : gap_a;
    end_n     = cur_rep ? (cnt_n == 16'd0) : fire;
    dly_n     = sat_sub(cur_dly, delta_q);
  end

  // memory write port select
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q;
    mem_wd = {dly_n, gap_n, cur_rld, cnt_n};
    if (ctl_i.create && create_ok) begin
      mem_we = 1'b1;
      mem_wa = slot_addr;
      mem_wd = {dly_in_q, {TimeWidth{1'b0}}, gap_in_q, cnt_in_q};
    end else if (ctl_i.scan_exec) begin
      mem_we = 1'b1;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_wa] <= mem_wd;
    end
    if (ctl_i.scan_read) begin
      rd_q <= slot_mem_q[idx_q];
    end
  end

  // input word latch
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      op_q     <= in_data_i.cmd;
      slot_q   <= in_data_i.slot;
      rep_q    <= in_data_i.repeat_mode;
      dly_in_q <= load_time(in_data_i.delay_ticks);
      gap_in_q <= load_time(in_data_i.gap_ticks);
      cnt_in_q <= in_data_i.repeat_count;
      delta_q  <= load_time(in_data_i.delta_ticks);
    end
  end

  // slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q   <= '0;
      ended_q    <= '0;
      rep_mode_q <= '0;
    end else begin
      if (ctl_i.create && create_ok) begin
        in_use_q[slot_addr]   <= 1'b1;
        ended_q[slot_addr]    <= 1'b0;
        rep_mode_q[slot_addr] <= rep_q;
      end
      if (ctl_i.destroy && slot_ok) begin
        in_use_q[slot_addr] <= 1'b0;
      end
      if (ctl_i.scan_exec) begin
        ended_q[idx_q] <= end_n;
      end
    end
  end

  // scan index and held fire word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      pend_slot_q  <= '0;
    end else begin
      if (ctl_i.scan_start) begin
        idx_q        <= '0;
        pend_valid_q <= 1'b0;
      end
      if (ctl_i.scan_skip || ctl_i.scan_exec) begin
        idx_q <= idx_q + SlotW'(1);
      end
      if (ctl_i.scan_exec && fire) begin
        pend_valid_q <= 1'b1;
        pend_slot_q  <= idx_q;
      end
      if (ctl_i.flush) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.create || ctl_i.flush ||
                 (ctl_i.scan_exec && fire && pend_valid_q)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.create) begin
      out_data_q.kind    <= create_ok ? mset_pkg::KIND_CREATED : mset_pkg::KIND_REFUSED;
      out_data_q.slot_id <= slot_q;
      out_data_q.last    <= 1'b1;
    end else if (ctl_i.flush || (ctl_i.scan_exec && fire && pend_valid_q)) begin
      out_data_q.kind    <= mset_pkg::KIND_FIRED;
      out_data_q.slot_id <= pend_ext[3:0];
      out_data_q.last    <= ctl_i.flush;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // status to the controller
  assign sts_o.op          = op_q;
  assign sts_o.out_free    = out_free;
  assign sts_o.slot_active = in_use_q[idx_q] && !ended_q[idx_q];
  assign sts_o.idx_last    = idx_q == SlotW'(NumSlots - 1);
  assign sts_o.pend_valid  = pend_valid_q;
  assign sts_o.ex_stall    = fire && pend_valid_q && !out_free;

endmodule
